FILE: hdl/lesf_pkg.sv
// Shared constants and types for the largest empty square finder.
`default_nettype none
package lesf_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int LEN_W   = 11;
    localparam int SCORE_W = 11;
    localparam int SYM_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBSTACLE   = 2'd0,
        CFG_ROW_LENGTH = 2'd1,
        CFG_ROW_COUNT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] size;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } t_result;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] hi);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/lesf_out_q.sv
// Two-entry result queue that decouples the score pipeline from the output stall.
`default_nettype none
module lesf_out_q (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire lesf_pkg::t_result i_data,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output lesf_pkg::t_result      o_data,
    output logic [1:0]             o_count
);
    import lesf_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_q0, n_q0;
    t_result    r_q1, n_q1;
    logic       pop;

    assign pop = (r_cnt != 2'd0) && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        if (pop && i_push) begin
            if (r_cnt == 2'd1) begin
                n_q0 = i_data;
            end else begin
                n_q0 = r_q1;
                n_q1 = i_data;
            end
        end else if (pop) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 2'd1;
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                n_q0 = i_data;
            end else begin
                n_q1 = i_data;
            end
            n_cnt = r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;
    assign o_count = r_cnt;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_cnt == 2'd2) |-> pop)
        else $error("result queue overflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: hdl/largest_empty_square_finder_unit.sv
// Top level: streaming maximal-square scorer with a one-row score buffer in RAM.
//
// Grid cells enter one symbol per transfer in row-major order, one per cycle
// when the output side keeps up. Each cell is scored in a two-step pipeline:
// the accept cycle reads the upper score from the row RAM (a registered read),
// and the next cycle forms min(up, left, diagonal) + 1, writes it back
// and updates the best square. A write and a read of the same column in one
// cycle (single-column grids) is forwarded. After the last cell of a grid one
// result (size, bottom-right row and column) enters a two-entry output queue;
// input is stalled only when that queue could not absorb another result.
// Configuration is to be written through a simple write port while the block
// is idle; the block does not enforce this. Zero lengths count as one and
// lengths above 1024 count as 1024. The row RAM has no reset.
`default_nettype none
module largest_empty_square_finder_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [lesf_pkg::SYM_W-1:0]      i_cell_symbol,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [lesf_pkg::SCORE_W-1:0]         o_square_size,
    output logic [lesf_pkg::ROW_W-1:0]           o_corner_row,
    output logic [lesf_pkg::COL_W-1:0]           o_corner_col,
    input  wire logic                            i_cfg_we,
    input  wire logic [lesf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lesf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lesf_pkg::*;

    // configuration
    logic [SYM_W-1:0] r_obstacle;
    logic [LEN_W-1:0] r_row_length;
    logic [LEN_W-1:0] r_row_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle   <= SYM_W'(111);
            r_row_length <= LEN_W'(MAX_COLS);
            r_row_count  <= LEN_W'(MAX_ROWS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OBSTACLE:   r_obstacle   <= i_cfg_data[SYM_W-1:0];
                CFG_ROW_LENGTH: r_row_length <= i_cfg_data[LEN_W-1:0];
                CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] cols, rows;
    assign cols = clamp_len(r_row_length, LEN_W'(MAX_COLS));
    assign rows = clamp_len(r_row_count, LEN_W'(MAX_ROWS));

    // stage 0: accept, position tracking, RAM read
    logic             accept;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             eol, eog;

    assign accept = i_in_valid && !o_in_stall;
    assign eol    = ({1'b0, r_col} + LEN_W'(1)) >= cols;
    assign eog    = eol && (({1'b0, r_row} + LEN_W'(1)) >= rows);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (eol) begin
                n_col = '0;
                n_row = eog ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // stage 1 registers
    logic               r_s1_valid;
    logic               r_s1_obst;
    logic               r_s1_edge;
    logic               r_s1_eol;
    logic               r_s1_eog;
    logic [ROW_W-1:0]   r_s1_row;
    logic [COL_W-1:0]   r_s1_col;
    logic [SCORE_W-1:0] r_left, r_diag;
    logic [SCORE_W-1:0] r_fwd;
    logic               r_fwd_hit;
    logic [SCORE_W-1:0] r_best_size;
    logic [ROW_W-1:0]   r_best_row;
    logic [COL_W-1:0]   r_best_col;

    // row score RAM
    logic [SCORE_W-1:0] r_mem [0:MAX_COLS-1];
    logic [SCORE_W-1:0] r_rd_data;
    logic [SCORE_W-1:0] score;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_col];
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= score;
        end
    end

    // stage 1: score, write back, best tracking
    logic [SCORE_W-1:0] up, m2, m3;
    logic               better;
    t_result            res;

    assign up = r_fwd_hit ? r_fwd : r_rd_data;
    assign m2 = (up < r_left) ? up : r_left;
    assign m3 = (m2 < r_diag) ? m2 : r_diag;

    always_comb begin
        if (r_s1_obst) begin
            score = '0;
        end else if (r_s1_edge) begin
            score = SCORE_W'(1);
        end else begin
            score = m3 + SCORE_W'(1);
        end
    end

    assign better = score > r_best_size;

    always_comb begin
        if (better) begin
            res.size = score;
            res.row  = r_s1_row;
            res.col  = r_s1_col;
        end else begin
            res.size = r_best_size;
            res.row  = r_best_row;
            res.col  = r_best_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
            r_fwd_hit  <= accept && r_s1_valid && (r_s1_col == r_col);
            if (r_s1_valid) begin
                r_left <= r_s1_eol ? '0 : score;
                r_diag <= r_s1_eol ? '0 : up;
                if (r_s1_eog) begin
                    r_best_size <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                end else if (better) begin
                    r_best_size <= score;
                    r_best_row  <= r_s1_row;
                    r_best_col  <= r_s1_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd <= score;
        if (accept) begin
            r_s1_obst <= (i_cell_symbol == r_obstacle);
            r_s1_edge <= (r_row == '0) || (r_col == '0);
            r_s1_eol  <= eol;
            r_s1_eog  <= eog;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
        end
    end

    // output queue and input stall
    logic       push, pop;
    logic [1:0] q_count;
    t_result    q_data;

    assign push = r_s1_valid && r_s1_eog;
    assign pop  = o_out_valid && !i_out_stall;

    lesf_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_in_stall = ({1'b0, q_count} + {2'b00, push}) >= (3'd2 + {2'b00, pop});

    assign o_square_size = q_data.size;
    assign o_corner_row  = q_data.row;
    assign o_corner_col  = q_data.col;

    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted cell did not reach the score stage");

    a_best_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_eog) |=> (r_best_size == '0))
        else $error("best square not cleared after grid end");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> ($past(r_s1_valid) && r_s1_valid))
        else $error("forwarded score without a write in flight");

    a_eog_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_eog) |-> r_s1_eol)
        else $error("grid end without row end");

endmodule
`default_nettype wire
